// File: hw/rtl/ilid_pkg.sv
// ----------------------------------------------------------------------------
// ilid_pkg: shared types and constants for the indexed list core
// Holds list depth, field widths, action and status codes, beat structs
// and the control word broadcast to the storage cells.
// ----------------------------------------------------------------------------
package ilid_pkg;

  localparam int DEPTH   = 32;
  localparam int DATA_W  = 32;
  localparam int POS_W   = 6;
  localparam int OUTCNT_W = 6;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int CMP_W   = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_DELETE = 2'd1,
    ACT_DUMP   = 2'd2
  } act_t;

  typedef enum logic [2:0] {
    ST_DONE  = 3'd0,
    ST_RANGE = 3'd1,
    ST_FULL  = 3'd2,
    ST_ELEM  = 3'd3,
    ST_EMPTY = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_DELETE,
    CELL_ROTATE
  } cell_op_t;

  typedef struct packed {
    logic [1:0]               action;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] item_value;
  } in_beat_t;

  typedef struct packed {
    logic [2:0]               status;
    logic signed [DATA_W-1:0] element_value;
    logic [OUTCNT_W-1:0]      entry_count;
    logic                     last;
  } out_beat_t;

  typedef struct packed {
    cell_op_t                 op;
    logic [CMP_W-1:0]         pos;
    logic [CMP_W-1:0]         last_idx;
    logic signed [DATA_W-1:0] value;
  } cell_ctrl_t;

endpackage

// File: hw/rtl/ilid_cell.sv
// ----------------------------------------------------------------------------
// ilid_cell: one storage cell of the list chain
// Holds one entry; takes the left or right neighbor, the new value or the
// head entry as the broadcast control word selects.
// ----------------------------------------------------------------------------
module ilid_cell (
  input  logic                               clk,
  input  logic [ilid_pkg::CMP_W-1:0]         cell_idx,
  input  ilid_pkg::cell_ctrl_t               ctrl,
  input  logic signed [ilid_pkg::DATA_W-1:0] left_d,
  input  logic signed [ilid_pkg::DATA_W-1:0] right_d,
  input  logic signed [ilid_pkg::DATA_W-1:0] head_d,
  output logic signed [ilid_pkg::DATA_W-1:0] data
);

  logic signed [ilid_pkg::DATA_W-1:0] data_r;
  logic signed [ilid_pkg::DATA_W-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    case (ctrl.op)
      ilid_pkg::CELL_INSERT: begin
        if (cell_idx == ctrl.pos) begin
          data_nxt = ctrl.value;
        end else if (cell_idx > ctrl.pos) begin
          data_nxt = left_d;
        end
      end
      ilid_pkg::CELL_DELETE: begin
        if (cell_idx >= ctrl.pos) begin
          data_nxt = right_d;
        end
      end
      ilid_pkg::CELL_ROTATE: begin
        // wrap the head entry around to the tail of the occupied span
        if (cell_idx == ctrl.last_idx) begin
          data_nxt = head_d;
        end else if (cell_idx < ctrl.last_idx) begin
          data_nxt = right_d;
        end
      end
      default: data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;

endmodule

// File: hw/rtl/indexed_list_insert_delete_core.sv
// ----------------------------------------------------------------------------
// indexed_list_insert_delete_core: ordered list with indexed insert/delete
// Row of storage cells that shift in parallel; dump streams the list out.
// ----------------------------------------------------------------------------
// Usage:
//   Drive in_item and raise start; the beat is taken at a clock edge where
//   start is high and busy is low. Results leave on out_item, one beat per
//   cycle marked by out_valid; the receiver cannot stall, so every beat
//   must be taken in the cycle it is shown.
//   Insert and delete: the whole row of cells shifts at once, and the
//   single status beat appears the cycle after the command is taken. A new
//   command may follow in every cycle (one item per cycle).
//   Dump: the row rotates one place per cycle toward cell 0, and cell 0 is
//   streamed out, so a list of N entries gives N beats on consecutive
//   cycles; the taken command sets dumping_r, and each beat is then
//   registered into out_item_r. Busy is high until the final beat is
//   launched, and only then is the next command taken. N rotations restore
//   the original order. An empty list gives one list-empty beat. An unused
//   action code is dropped with no result.
//   Reset clears the entry count, the dump sequencer and the result strobe;
//   cell contents are left as they are and are never read above the count.
// ----------------------------------------------------------------------------
module indexed_list_insert_delete_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  ilid_pkg::in_beat_t  in_item,
  output logic                out_valid,
  output ilid_pkg::out_beat_t out_item
);

  localparam int DEPTH = ilid_pkg::DEPTH;
  localparam int CMP_W = ilid_pkg::CMP_W;
  localparam int CNT_W = ilid_pkg::CNT_W;
  localparam int DATA_W = ilid_pkg::DATA_W;

  // control state
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic                dumping_r, dumping_nxt;
  logic [CNT_W-1:0]    dump_idx_r, dump_idx_nxt;
  logic                out_valid_r, out_valid_nxt;
  ilid_pkg::out_beat_t out_item_r, out_item_nxt;

  ilid_pkg::cell_ctrl_t ctrl;
  logic signed [DATA_W-1:0] cell_q [DEPTH];

  logic             accept;
  logic [CMP_W-1:0] pos_ext;
  logic [CMP_W-1:0] cnt_ext;

  assign accept  = start && !dumping_r;
  assign pos_ext = CMP_W'(in_item.position);
  assign cnt_ext = CMP_W'(count_r);

  always_comb begin
    count_nxt     = count_r;
    dumping_nxt   = dumping_r;
    dump_idx_nxt  = dump_idx_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    ctrl.op       = ilid_pkg::CELL_HOLD;
    ctrl.pos      = pos_ext;
    ctrl.last_idx = cnt_ext - CMP_W'(1);
    ctrl.value    = in_item.item_value;

    if (dumping_r) begin
      // stream the head cell and rotate the occupied span by one
      ctrl.op       = ilid_pkg::CELL_ROTATE;
      out_valid_nxt = 1'b1;
      out_item_nxt.status        = ilid_pkg::ST_ELEM;
      out_item_nxt.element_value = cell_q[0];
      out_item_nxt.entry_count   = ilid_pkg::OUTCNT_W'(count_r);
      out_item_nxt.last          = (dump_idx_r == count_r - CNT_W'(1));
      if (dump_idx_r == count_r - CNT_W'(1)) begin
        dumping_nxt = 1'b0;
      end
      dump_idx_nxt = dump_idx_r + CNT_W'(1);
    end else if (accept) begin
      out_item_nxt.element_value = '0;
      out_item_nxt.last          = 1'b1;
      out_item_nxt.status        = ilid_pkg::ST_DONE;
      case (in_item.action)
        ilid_pkg::ACT_INSERT: begin
          out_valid_nxt = 1'b1;
          if (pos_ext > cnt_ext) begin
            out_item_nxt.status = ilid_pkg::ST_RANGE;
          end else if (count_r == CNT_W'(DEPTH)) begin
            out_item_nxt.status = ilid_pkg::ST_FULL;
          end else begin
            ctrl.op   = ilid_pkg::CELL_INSERT;
            count_nxt = count_r + CNT_W'(1);
          end
        end
        ilid_pkg::ACT_DELETE: begin
          out_valid_nxt = 1'b1;
          if (pos_ext >= cnt_ext) begin
            out_item_nxt.status = ilid_pkg::ST_RANGE;
          end else begin
            ctrl.op   = ilid_pkg::CELL_DELETE;
            count_nxt = count_r - CNT_W'(1);
          end
        end
        ilid_pkg::ACT_DUMP: begin
          if (count_r == '0) begin
            out_valid_nxt       = 1'b1;
            out_item_nxt.status = ilid_pkg::ST_EMPTY;
          end else begin
            dumping_nxt  = 1'b1;
            dump_idx_nxt = '0;
          end
        end
        default: out_valid_nxt = 1'b0;
      endcase
      out_item_nxt.entry_count = ilid_pkg::OUTCNT_W'(count_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      dumping_r   <= 1'b0;
      dump_idx_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      dumping_r   <= dumping_nxt;
      dump_idx_r  <= dump_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload: no reset needed
  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  // row of cells; ends of the chain see zero
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [DATA_W-1:0] left_d;
    logic signed [DATA_W-1:0] right_d;

    if (i == 0) begin : g_first
      assign left_d = '0;
    end else begin : g_mid_l
      assign left_d = cell_q[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_d = '0;
    end else begin : g_mid_r
      assign right_d = cell_q[i+1];
    end

    ilid_cell u_cell (
      .clk      (clk),
      .cell_idx (CMP_W'(i)),
      .ctrl     (ctrl),
      .left_d   (left_d),
      .right_d  (right_d),
      .head_d   (cell_q[0]),
      .data     (cell_q[i])
    );
  end

  assign busy      = dumping_r;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // a dump never runs over an empty list
  a_dump_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    dumping_r |-> (count_r != '0))
    else $error("dump running with empty list");

  // the count never exceeds the list depth
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("entry count above depth");

  // a streamed element that is not last means the dump still runs
  a_elem_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_item_r.status == ilid_pkg::ST_ELEM && !out_item_r.last)
      |-> dumping_r)
    else $error("dump stopped before final element");

  // every status that is not a streamed element closes its command
  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_item_r.status != ilid_pkg::ST_ELEM) |-> out_item_r.last)
    else $error("single status beat not marked last");

  // the count holds while a dump streams
  a_dump_count: assert property (@(posedge clk) disable iff (!rst_n)
    dumping_r |=> (count_r == $past(count_r)))
    else $error("count changed during dump");

endmodule

// File: bench/ilid_list_monitor.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ilid_list_monitor: list predictor and result comparator
// Watches the command and result channels of the indexed list core. It keeps
// its own copy of the list, expands each taken command into the beats it
// should cause, and compares every result beat field by field with the
// oldest one still owed.
// ----------------------------------------------------------------------------
module ilid_list_monitor (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                busy,
  input  ilid_pkg::in_beat_t  in_item,
  input  logic                out_valid,
  input  ilid_pkg::out_beat_t out_item,
  output int                  fail_count,
  output int                  pending,
  output int                  held_count
);
  import ilid_pkg::*;

  logic signed [DATA_W-1:0] list_mem [DEPTH];
  int                       list_len;
  out_beat_t                owed_beats [$];
  out_beat_t                want;

  function automatic out_beat_t status_beat(status_t st, logic signed [DATA_W-1:0] v,
                                            logic fin);
    out_beat_t b;
    b.status        = st;
    b.element_value = v;
    b.entry_count   = OUTCNT_W'(list_len);
    b.last          = fin;
    return b;
  endfunction

  // Apply one command to the list copy and queue the beats it owes.
  task automatic apply_list_command(input in_beat_t cmd);
    int p;
    int i;
    p = int'(cmd.position);
    case (cmd.action)
      ACT_INSERT: begin
        // position check wins over the full check
        if (p > list_len) begin
          owed_beats.push_back(status_beat(ST_RANGE, '0, 1'b1));
        end else if (list_len >= DEPTH) begin
          owed_beats.push_back(status_beat(ST_FULL, '0, 1'b1));
        end else begin
          for (i = list_len; i > p; i--) list_mem[i] = list_mem[i-1];
          list_mem[p] = cmd.item_value;
          list_len++;
          owed_beats.push_back(status_beat(ST_DONE, '0, 1'b1));
        end
      end
      ACT_DELETE: begin
        if (p >= list_len) begin
          owed_beats.push_back(status_beat(ST_RANGE, '0, 1'b1));
        end else begin
          for (i = p; i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
          list_len--;
          owed_beats.push_back(status_beat(ST_DONE, '0, 1'b1));
        end
      end
      ACT_DUMP: begin
        if (list_len == 0) begin
          owed_beats.push_back(status_beat(ST_EMPTY, '0, 1'b1));
        end else begin
          for (i = 0; i < list_len; i++)
            owed_beats.push_back(status_beat(ST_ELEM, list_mem[i], i == list_len - 1));
        end
      end
      default: ; // unused code: dropped, no beat
    endcase
  endtask

  task automatic compare_field(input string name, input logic [DATA_W-1:0] want_v,
                               input logic [DATA_W-1:0] got_v);
    if (want_v !== got_v) begin
      fail_count++;
      $display("%0t ns: %s mismatch, expected %h, got %h", $time, name, want_v, got_v);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      list_len = 0;
      owed_beats.delete();
    end else begin
      if (out_valid) begin
        if (owed_beats.size() == 0) begin
          fail_count++;
          $display("%0t ns: unexpected beat, expected none, got status %0d value %h",
                   $time, out_item.status, out_item.element_value,
                   " count %0d last %b", out_item.entry_count, out_item.last);
        end else begin
          want = owed_beats.pop_front();
          compare_field("status", DATA_W'(want.status), DATA_W'(out_item.status));
          compare_field("element_value", want.element_value, out_item.element_value);
          compare_field("entry_count", DATA_W'(want.entry_count),
                        DATA_W'(out_item.entry_count));
          compare_field("last", DATA_W'(want.last), DATA_W'(out_item.last));
        end
      end
      if (start && !busy) apply_list_command(in_item);
    end
    pending    = owed_beats.size();
    held_count = list_len;
  end

endmodule

// File: bench/tb_indexed_list_insert_delete_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_indexed_list_insert_delete_core: stimulus and verdict for the list core
// Drives a directed pass over the edge cases (empty and full list, range
// errors, ends of the list, extreme values, unused code), then random
// command streams that grow, shrink and churn the list, with random sender
// pauses. A side monitor predicts and checks every result beat.
// ----------------------------------------------------------------------------
module tb_indexed_list_insert_delete_core;
  import ilid_pkg::*;

  localparam logic [1:0] ACT_UNUSED = 2'd3;  // code the core must drop
  localparam int RANDOM_ITEMS = 430;
  localparam int TAIL_START   = 380;         // no pauses from here on
  localparam int QUIET_LIMIT  = 300;         // cycles with no beat moving
  localparam int DRAIN_CYCLES = 4;

  typedef enum int {MIX_GROW, MIX_SHRINK, MIX_EVEN, MIX_NOISE} mix_t;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_beat_t  in_item;
  logic      out_valid;
  out_beat_t out_item;

  int fail_count;
  int pending;
  int held_count;
  int quiet_cycles;
  int items_sent;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  indexed_list_insert_delete_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  ilid_list_monitor list_mon (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_item   (out_item),
    .fail_count (fail_count),
    .pending    (pending),
    .held_count (held_count)
  );

  // Watchdog: a beat moving on either channel rearms it.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAIL indexed_list_insert_delete_core");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic in_beat_t make_cmd(logic [1:0] act, int pos, logic [DATA_W-1:0] v);
    in_beat_t c;
    c.action     = act;
    c.position   = POS_W'(pos);
    c.item_value = v;
    return c;
  endfunction

  // Present one command beat from a falling edge and hold it until a rising
  // edge takes it (start high, busy low). Return at the next falling edge
  // with start still high, so a follow-on beat needs no extra toggle.
  task automatic send_beat(input in_beat_t cmd);
    start   <= 1'b1;
    in_item <= cmd;
    do begin
      @(posedge clk);
    end while (busy);
    @(negedge clk);
    items_sent++;
  endtask

  // Drop start for a random burst with the given odds, in percent.
  task automatic maybe_pause(input int pct);
    if ($urandom_range(0, 99) < pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
  endtask

  // Mostly random words, with the extremes mixed in now and then.
  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 15))
      0:       return {1'b1, {(DATA_W-1){1'b0}}};
      1:       return {1'b0, {(DATA_W-1){1'b1}}};
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    mix_t       mode;
    int         mode_left;
    int         idle_pct;
    int         ins_pct;
    int         del_pct;
    int         roll;
    int         pos;
    logic [1:0] act;

    rst_n      = 1'b0;
    start      = 1'b0;
    in_item    = '0;
    items_sent = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // ---- directed pass ----
    // Empty list: dump reports empty, deletes and a past-the-end insert fail.
    send_beat(make_cmd(ACT_DUMP, 0, '0));
    send_beat(make_cmd(ACT_DELETE, 0, '0));
    send_beat(make_cmd(ACT_DELETE, 63, '1));
    send_beat(make_cmd(ACT_INSERT, 1, 32'd5));
    // Build four entries: append, front and middle inserts, extreme values.
    send_beat(make_cmd(ACT_INSERT, 0, 32'h8000_0000));
    send_beat(make_cmd(ACT_INSERT, 1, 32'h7FFF_FFFF));
    send_beat(make_cmd(ACT_INSERT, 0, 32'hFFFF_FFFF));
    send_beat(make_cmd(ACT_INSERT, 1, 32'h0000_0000));
    // Insert beyond the end: far out and just one past the count.
    send_beat(make_cmd(ACT_INSERT, 63, 32'd123));
    send_beat(make_cmd(ACT_INSERT, 5, 32'd77));
    send_beat(make_cmd(ACT_DUMP, 63, '1));
    // Delete at the count and far past it.
    send_beat(make_cmd(ACT_DELETE, 4, '0));
    send_beat(make_cmd(ACT_DELETE, 63, '0));
    // Unused code with every field bit set, then with all clear.
    send_beat(make_cmd(ACT_UNUSED, 63, '1));
    send_beat(make_cmd(ACT_UNUSED, 0, '0));
    // Delete middle, last and front, then drain to empty.
    send_beat(make_cmd(ACT_DELETE, 1, '1));
    send_beat(make_cmd(ACT_DELETE, 2, '0));
    send_beat(make_cmd(ACT_DELETE, 0, '0));
    send_beat(make_cmd(ACT_DUMP, 0, '0));
    send_beat(make_cmd(ACT_DELETE, 0, '0));
    send_beat(make_cmd(ACT_DUMP, 0, '0));
    send_beat(make_cmd(ACT_INSERT, 0, $urandom));

    // ---- fill to the top ----
    // Grow with valid positions until full, then knock on the full list:
    // positions up to the count report full, past it report out of range.
    while (held_count < DEPTH) begin
      maybe_pause(20);
      if ($urandom_range(0, 9) == 0)
        send_beat(make_cmd(ACT_DUMP, $urandom_range(0, 63), $urandom));
      else
        send_beat(make_cmd(ACT_INSERT, $urandom_range(0, held_count), pick_value()));
    end
    send_beat(make_cmd(ACT_INSERT, 0, pick_value()));
    send_beat(make_cmd(ACT_INSERT, DEPTH, pick_value()));
    send_beat(make_cmd(ACT_INSERT, DEPTH + 1, pick_value()));
    send_beat(make_cmd(ACT_INSERT, 63, pick_value()));
    send_beat(make_cmd(ACT_DUMP, 0, '0));

    // ---- random streams ----
    // Each stretch favors growth, shrinkage, an even mix or raw noise, and
    // carries its own pause rate (some stretches run without pauses).
    mode      = MIX_EVEN;
    mode_left = 0;
    idle_pct  = 0;
    while (items_sent < RANDOM_ITEMS) begin
      if (mode_left == 0) begin
        mode      = mix_t'($urandom_range(0, 3));
        mode_left = $urandom_range(15, 40);
        idle_pct  = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 40);
      end
      mode_left--;

      case (mode)
        MIX_GROW:   begin ins_pct = 70; del_pct = 10; end
        MIX_SHRINK: begin ins_pct = 10; del_pct = 70; end
        default:    begin ins_pct = 40; del_pct = 40; end
      endcase

      roll = $urandom_range(0, 99);
      if (mode == MIX_NOISE || roll >= 90) begin
        // noise: any code, any position
        act = 2'($urandom_range(0, 3));
        pos = $urandom_range(0, 63);
      end else if (roll < ins_pct) begin
        act = ACT_INSERT;
        case ($urandom_range(0, 9))
          0:       pos = 0;
          1:       pos = held_count;
          default: pos = $urandom_range(0, held_count);
        endcase
      end else if (roll < ins_pct + del_pct) begin
        act = ACT_DELETE;
        pos = (held_count == 0) ? 0 : $urandom_range(0, held_count - 1);
      end else begin
        act = ACT_DUMP;
        pos = $urandom_range(0, 63);
      end

      maybe_pause((items_sent >= TAIL_START) ? 0 : idle_pct);
      send_beat(make_cmd(act, pos, pick_value()));
    end

    // ---- drain ----
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("PASS indexed_list_insert_delete_core");
    end else begin
      $display("FAIL indexed_list_insert_delete_core");
    end
    $finish;
  end

endmodule
